/* rtl/console_line_editor_assert.svh */
// Assertion macros used by the console line editor top level.
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CLM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CLM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/clm_pkg.sv */
// Types and constants of the console line editor.
package clm_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ECHO   = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_PROMPT = 2'd2
  } kind_e;

  // Which line end was seen last.
  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_CR   = 2'd1,
    END_LF   = 2'd2
  } line_end_e;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_SP  = 8'h20;

  // One result beat.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

/* rtl/clm_if.sv */
// Valid/ready channel interfaces for received bytes and for results.
interface clm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface clm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink (input valid, input kind, input data, input last, output ready);
endinterface

/* rtl/clm_line_ram.sv */
// Line buffer memory: one write port, one read port with registered read data.
module clm_line_ram #(
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/clm_out_reg.sv */
// Output register stage that holds one result beat until it is taken.
module clm_out_reg
  import clm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t item_i,
  output logic    can_load_o,
  clm_out_if.source res_o
);

  logic    valid_q, valid_d;
  result_t item_q;

  assign can_load_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign res_o.valid = valid_q;
  assign res_o.kind  = item_q.kind;
  assign res_o.data  = item_q.data;
  assign res_o.last  = item_q.last;

endmodule

/* rtl/console_line_editor.sv */
// Console line editor top level: byte decode, sequencer and line buffer walk.
// The editor takes one received console byte per beat on rx_i and produces
// echo bytes, completed-line bytes and prompt requests on res_o, with last set
// on the final result of each received byte. A received byte is accepted only
// while the sequencer is idle; a result still waiting in the output register
// does not hold off the next byte. A plain byte is accepted, then echoed and
// written to the line buffer; an erase on a non-empty line is accepted, then
// echoed as backspace, space, backspace; a line end is accepted, then echoed
// as a newline, followed by a prompt request after an empty line, or by a walk
// over the line buffer, which reads its single read port once per cycle while
// the output register can take each result. The line buffer needs no clearing
// after reset: only entries below the write position are ever read, and those
// were written in the same line.
`include "console_line_editor_assert.svh"

module console_line_editor
  import clm_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  clm_in_if.sink    rx_i,
  clm_out_if.source res_o
);

  localparam int PosW = $clog2(LINE_DEPTH);
  localparam logic [PosW-1:0] PosMax = PosW'(LINE_DEPTH - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ECHO   = 3'd1;
  localparam logic [2:0] S_ERASE  = 3'd2;
  localparam logic [2:0] S_NL     = 3'd3;
  localparam logic [2:0] S_PROMPT = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [PosW-1:0] wp_q, wp_d;
  line_end_e       end_q, end_d;
  logic [1:0]      step_q, step_d;
  logic [PosW-1:0] issue_idx_q, issue_idx_d;
  logic [PosW-1:0] emit_idx_q, emit_idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic [7:0]      ch_q;

  logic            accept;
  logic            is_cr, is_lf, is_erase, is_pair;
  logic            can_load, load;
  result_t         item;
  logic            push, rd_issue, walk_last;
  logic            ram_we;
  logic [PosW-1:0] wr_pos;
  logic [7:0]      ram_rdata;

  assign rx_i.ready = (state_q == S_IDLE);
  assign accept     = rx_i.valid && rx_i.ready;

  // Classify the incoming byte against the line end seen before it.
  assign is_cr    = (rx_i.rx_byte == CH_CR);
  assign is_lf    = (rx_i.rx_byte == CH_LF);
  assign is_erase = (rx_i.rx_byte == CH_DEL) || (rx_i.rx_byte == CH_BS);
  assign is_pair  = (is_cr && end_q == END_LF) || (is_lf && end_q == END_CR);

  // A stored byte that would fill the buffer restarts the line at zero.
  assign wr_pos = (wp_q == PosMax) ? '0 : wp_q;

  // Line walk: a read is in flight or its data waits in the memory register
  // while rd_vld_q is set; the next read is issued as that data is pushed.
  assign push      = (state_q == S_WALK) && rd_vld_q && can_load;
  assign rd_issue  = (state_q == S_WALK) && (!rd_vld_q || push) && (issue_idx_q != wp_q);
  assign walk_last = (emit_idx_q == wp_q - PosW'(1));

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    end_d       = end_q;
    step_d      = step_q;
    issue_idx_d = issue_idx_q;
    emit_idx_d  = emit_idx_q;
    rd_vld_d    = rd_vld_q;
    load        = 1'b0;
    ram_we      = 1'b0;
    item        = '{kind: KIND_ECHO, data: CH_LF, last: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_pair) begin
            end_d = END_NONE;
          end else if (is_cr) begin
            end_d   = END_CR;
            state_d = S_NL;
          end else if (is_lf) begin
            end_d   = END_LF;
            state_d = S_NL;
          end else begin
            end_d = END_NONE;
            if (is_erase) begin
              step_d = 2'd0;
              if (wp_q != '0) begin
                state_d = S_ERASE;
              end
            end else begin
              state_d = S_ECHO;
            end
          end
        end
      end
      S_ECHO: begin
        item = '{kind: KIND_ECHO, data: ch_q, last: 1'b1};
        if (can_load) begin
          load    = 1'b1;
          ram_we  = 1'b1;
          wp_d    = wr_pos + PosW'(1);
          state_d = S_IDLE;
        end
      end
      S_ERASE: begin
        // Backspace, space, backspace.
        item = '{kind: KIND_ECHO, data: (step_q == 2'd1) ? CH_SP : CH_BS,
                 last: (step_q == 2'd2)};
        if (can_load) begin
          load   = 1'b1;
          step_d = step_q + 2'd1;
          if (step_q == 2'd2) begin
            wp_d    = wp_q - PosW'(1);
            state_d = S_IDLE;
          end
        end
      end
      S_NL: begin
        item = '{kind: KIND_ECHO, data: CH_LF, last: 1'b0};
        if (can_load) begin
          load        = 1'b1;
          issue_idx_d = '0;
          emit_idx_d  = '0;
          rd_vld_d    = 1'b0;
          state_d     = (wp_q == '0) ? S_PROMPT : S_WALK;
        end
      end
      S_PROMPT: begin
        item = '{kind: KIND_PROMPT, data: 8'h00, last: 1'b1};
        if (can_load) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        item = '{kind: KIND_LINE, data: ram_rdata, last: walk_last};
        if (rd_issue) begin
          issue_idx_d = issue_idx_q + PosW'(1);
          rd_vld_d    = 1'b1;
        end else if (push) begin
          rd_vld_d = 1'b0;
        end
        if (push) begin
          load       = 1'b1;
          emit_idx_d = emit_idx_q + PosW'(1);
          if (walk_last) begin
            wp_d    = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      end_q       <= END_NONE;
      step_q      <= 2'd0;
      issue_idx_q <= '0;
      emit_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      end_q       <= end_d;
      step_q      <= step_d;
      issue_idx_q <= issue_idx_d;
      emit_idx_q  <= emit_idx_d;
      rd_vld_q    <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= rx_i.rx_byte;
    end
  end

  // Writes happen only in the echo state and reads only in the walk state,
  // so the two ports never touch the same entry in one cycle.
  clm_line_ram #(
    .Depth (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_pos),
    .wdata_i (ch_q),
    .re_i    (rd_issue),
    .raddr_i (issue_idx_q),
    .rdata_o (ram_rdata)
  );

  clm_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .item_i     (item),
    .can_load_o (can_load),
    .res_o      (res_o)
  );

  // The write position never reaches the buffer depth.
  `CLM_ASSERT_SAME(a_wp_range, clk_i, rst_ni, 1'b1, wp_q <= PosMax, "write position out of range")
  // A result is never loaded over one that has not been taken.
  `CLM_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, load, can_load, "output overwrite")
  // Pending read data always belongs to a stored byte.
  `CLM_ASSERT_SAME(a_walk_bound, clk_i, rst_ni, (state_q == S_WALK) && rd_vld_q,
                   emit_idx_q < wp_q, "line walk beyond stored bytes")
  // Completing the line walk empties the line.
  `CLM_ASSERT_NEXT(a_walk_reset, clk_i, rst_ni, push && walk_last,
                   (wp_q == '0) && (state_q == S_IDLE), "line not reset after walk")

endmodule
